// File: design/brfe_pkg.sv
// ----------------------------------------------------------------------------
// brfe_pkg
// Types and constants shared by the byte ring and frame extractor modules.
// ----------------------------------------------------------------------------
package brfe_pkg;

  localparam int RingDepthDefault = 64;
  localparam int FrameCap         = 63;
  localparam int QueueDepth       = 2;
  localparam int CmpW             = 9;

  localparam logic [7:0] HeaderReset = 8'hAA;

  localparam logic [1:0] StStored  = 2'd0;
  localparam logic [1:0] StRefused = 2'd1;
  localparam logic [1:0] StFrame   = 2'd2;
  localparam logic [1:0] StNone    = 2'd3;

  localparam logic KindWrite = 1'b0;

  typedef enum logic [1:0] {
    OP_WR_NEW,
    OP_WR_CONT,
    OP_FETCH
  } op_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       block_start;
    logic [7:0] block_length;
  } brfe_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_byte;
    logic       last;
    logic [5:0] frame_length;
    logic [5:0] fill_count;
  } brfe_out_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [7:0] len;
  } brfe_cmd_t;

endpackage

// File: design/brfe_front.sv
// ----------------------------------------------------------------------------
// brfe_front
// Accepts input items and turns each into a command: the start of a write
// block with its normalized length, a further byte of the open block, or a
// frame fetch.
// ----------------------------------------------------------------------------
module brfe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  brfe_pkg::brfe_in_t  in_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output brfe_pkg::brfe_cmd_t push_o
);
  import brfe_pkg::*;

  logic [7:0] left_q, left_d;
  logic [7:0] len;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  always_comb begin
    len    = 8'd1;
    left_d = left_q;
    push_o = '{op: OP_FETCH, data: in_i.data_byte, len: 8'd1};
    if (in_i.kind == KindWrite) begin
      if (in_i.block_start || left_q == 8'd0) begin
        if (in_i.block_start && in_i.block_length != 8'd0) begin
          len = in_i.block_length;
        end
        push_o.op  = OP_WR_NEW;
        push_o.len = len;
        left_d     = len - 8'd1;
      end else begin
        push_o.op = OP_WR_CONT;
        left_d    = left_q - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 8'd0;
    end else if (in_valid_i && push_ready_i && in_i.kind == KindWrite) begin
      left_q <= left_d;
    end
  end

endmodule

// File: design/brfe_queue.sv
// ----------------------------------------------------------------------------
// brfe_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module brfe_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  brfe_pkg::brfe_cmd_t push_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output brfe_pkg::brfe_cmd_t pop_o
);
  import brfe_pkg::*;

  localparam int AW = $clog2(QueueDepth);

  brfe_cmd_t          entries_q [QueueDepth];
  logic [AW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [AW:0]        count_q, count_d;
  logic               push, pop;

  assign push_ready_o = count_q != (AW + 1)'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_o        = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

// File: design/brfe_back.sv
// ----------------------------------------------------------------------------
// brfe_back
// Holds the ring memory and its pointers, stores or refuses write bytes,
// runs the frame search and emission, and drives the output register.
// ----------------------------------------------------------------------------
module brfe_back #(
  parameter int RING_DEPTH = brfe_pkg::RingDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  brfe_pkg::brfe_cmd_t pop_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output brfe_pkg::brfe_out_t out_o
);
  import brfe_pkg::*;

  localparam int PW    = $clog2(RING_DEPTH);
  localparam int Limit = (RING_DEPTH - 1 < FrameCap) ? RING_DEPTH - 1 : FrameCap;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR_RD,
    S_HDR_CHK,
    S_LEN_CHK,
    S_BYTE_RD,
    S_BYTE_OUT,
    S_NONE
  } state_e;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [7:0]  mem [RING_DEPTH];
  logic [7:0]  rdata_q;
  logic        rd_en, wr_en;
  logic [PW-1:0] rd_addr;

  state_e      state_q, state_d;
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d, after_q, after_d;
  logic        acc_q, acc_d;
  logic [5:0]  left_q, left_d, flen_q, flen_d;
  logic [7:0]  header_q, header_d;
  brfe_out_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic [PW-1:0] fill, room;

  assign fill        = (wp_q >= rp_q) ? wp_q - rp_q : PW'(RING_DEPTH) + wp_q - rp_q;
  assign room        = PW'(RING_DEPTH - 1) - fill;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    after_d     = after_q;
    acc_d       = acc_q;
    left_d      = left_q;
    flen_d      = flen_q;
    header_d    = cfg_valid_i ? cfg_data_i : header_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_ready_o = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    rd_addr     = rp_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          if (pop_i.op == OP_FETCH) begin
            pop_ready_o = 1'b1;
            state_d     = S_HDR_RD;
          end else if (out_free) begin
            pop_ready_o = 1'b1;
            if (pop_i.op == OP_WR_NEW) begin
              acc_d = CmpW'(pop_i.len) <= CmpW'(room);
            end
            wr_en       = acc_d;
            out_valid_d = 1'b1;
            out_d       = '{status: StRefused, out_byte: 8'd0, last: 1'b1,
                            frame_length: 6'd0, fill_count: 6'(fill)};
            if (acc_d) begin
              wp_d             = ptr_next(wp_q);
              out_d.status     = StStored;
              out_d.fill_count = 6'(fill + 1'b1);
            end
          end
        end
      end
      S_HDR_RD: begin
        if (fill == '0) begin
          state_d = S_NONE;
        end else begin
          rd_en   = 1'b1;
          state_d = S_HDR_CHK;
        end
      end
      S_HDR_CHK: begin
        if (rdata_q != header_q) begin
          rp_d    = ptr_next(rp_q);
          state_d = S_HDR_RD;
        end else if (fill < PW'(2)) begin
          state_d = S_NONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_next(rp_q);
          state_d = S_LEN_CHK;
        end
      end
      S_LEN_CHK: begin
        if (rdata_q < 8'd2 || rdata_q > 8'(Limit)) begin
          rp_d    = ptr_next(rp_q);
          state_d = S_HDR_RD;
        end else if (CmpW'(rdata_q) > CmpW'(fill)) begin
          state_d = S_NONE;
        end else begin
          flen_d  = 6'(rdata_q);
          left_d  = 6'(rdata_q);
          after_d = fill - PW'(rdata_q);
          state_d = S_BYTE_RD;
        end
      end
      S_BYTE_RD: begin
        rd_en   = 1'b1;
        state_d = S_BYTE_OUT;
      end
      S_BYTE_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{status: StFrame, out_byte: rdata_q, last: left_q == 6'd1,
                          frame_length: flen_q, fill_count: 6'(after_q)};
          rp_d        = ptr_next(rp_q);
          left_d      = left_q - 6'd1;
          state_d     = (left_q == 6'd1) ? S_IDLE : S_BYTE_RD;
        end
      end
      S_NONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{status: StNone, out_byte: 8'd0, last: 1'b1,
                          frame_length: 6'd0, fill_count: 6'(fill)};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      acc_q       <= 1'b0;
      left_q      <= 6'd0;
      header_q    <= HeaderReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      acc_q       <= acc_d;
      left_q      <= left_d;
      header_q    <= header_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    after_q <= after_d;
    flen_q  <= flen_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wp_q] <= pop_i.data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule

// File: design/byte_ring_with_frame_extractor_top.sv
// ----------------------------------------------------------------------------
// byte_ring_with_frame_extractor_top
// Byte ring buffer fed by write blocks and drained by header/length frames.
// ----------------------------------------------------------------------------
// Input items pass through a two-entry command queue, so up to two items are
// taken while the back is busy. A write byte is stored or refused by the back
// and gives one result. A fetch runs on the single read port of the ring
// memory, whose read data is registered: the back takes the fetch, then for
// each byte examined in the header search, the header included, reads it and
// checks it, then checks the length byte, and reads and emits each frame byte
// in turn. A fetch that finds no frame gives a single no-frame result. A
// stalled result holds the back from giving another result until it is taken.
module byte_ring_with_frame_extractor_top #(
  parameter int RING_DEPTH = brfe_pkg::RingDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  brfe_pkg::brfe_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output brfe_pkg::brfe_out_t out_o
);
  import brfe_pkg::*;

  brfe_cmd_t push_cmd, pop_cmd;
  logic      push_valid, push_ready, pop_valid, pop_ready;

  brfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_o       (push_cmd)
  );

  brfe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_i       (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_o        (pop_cmd)
  );

  brfe_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// File: design/brfe_checker.sv
// ----------------------------------------------------------------------------
// brfe_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module brfe_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input brfe_pkg::brfe_out_t out_o
);
  import brfe_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("Result changed while stalled.");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != StFrame |-> out_o.last)
    else $error("Non-frame result without last marker.");

  a_single_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != StFrame |->
      out_o.out_byte == 8'd0 && out_o.frame_length == 6'd0)
    else $error("Non-frame result carries frame data.");

  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == StFrame |-> out_o.frame_length >= 6'd2)
    else $error("Frame byte with a length below two.");

endmodule

bind byte_ring_with_frame_extractor_top brfe_checker u_brfe_checker (.*);
